FILE: sv/sfn_pkg.sv
// Shared constants, word types and controller states of the spectral flux novelty core.
// Depends on nothing; the core and its testbench import it, sfn_ram does not.
package sfn_pkg;

  // Frame geometry
  localparam int NUM_BINS = 64;
  localparam int POS_W    = $clog2(NUM_BINS);

  // Field widths
  localparam int MAG_W   = 24;
  localparam int ACC_W   = 30;
  localparam int ALPHA_W = 16;
  localparam int NOV_W   = 16;
  localparam int FRAC_W  = 12;   // fraction bits of the Q4.12 novelty

  // Datapath widths of the baseline multiply
  localparam int HI_W   = ACC_W + 2;
  localparam int PROD_W = HI_W + ALPHA_W;

  localparam logic [ACC_W-1:0]   ACC_MAX     = '1;
  localparam logic [NOV_W-1:0]   NOVELTY_MAX = 16'd40960;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd64880;
  localparam logic [PROD_W-1:0]  ROUND_HALF  = PROD_W'(32768);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 1'd1;

  // Input word kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // Serial step counts
  localparam int ACC_STEPS = ACC_W;
  localparam int MUL_STEPS = ALPHA_W;
  localparam int DIV_STEPS = NOV_W;
  localparam int CNT_W     = $clog2(ACC_STEPS);

  typedef struct packed {
    logic             kind;
    logic [MAG_W-1:0] magnitude;
  } in_word_t;

  typedef struct packed {
    logic [NOV_W-1:0] novelty;
    logic [ACC_W-1:0] flux_sum;
    logic [ACC_W-1:0] baseline_level;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_ACCUM,
    ST_MPREP,
    ST_MULT,
    ST_MIX,
    ST_DINIT,
    ST_DIV,
    ST_EMIT
  } sfn_state_t;

endpackage

FILE: sv/spectral_flux_novelty_core.sv
// Spectral flux novelty core: bit-serial rectified flux, EMA baseline and novelty divide.
// Depends on sfn_pkg and on sfn_ram for the previous-frame bin store.
//
//   port group  direction  handshake           word
//   in          to core    in_valid/in_stall   in_word  (kind, magnitude)
//   out         from core  out_valid/out_stall out_word (novelty, flux_sum, baseline_level)
//   cfg         to core    cfg_write           cfg_index, cfg_data
//
// A clear word, and any bin word while disabled, is taken in the idle state; the last bin
// of a frame while disabled adds the output load, which waits while out_stall holds.
// An enabled bin word goes through accept, bin store read and 30 bit-serial add steps.
// The last bin of a frame adds a multiply setup state, 16 multiply steps for the baseline,
// a mix state, a divide setup state, 16 restoring divide steps and the output load, which
// waits while out_stall holds.
// Synchronous reset clears history and control registers and sets the baseline to 1 at once; no clearing pass.
// A finished result waits in the output register; only the next result load waits on it.
module spectral_flux_novelty_core
  import sfn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sfn_state_t state, state_next;

  // Configuration and frame state
  logic                 enabled;
  logic [ALPHA_W-1:0]   baseline_alpha;
  logic [POS_W-1:0]     pos;
  logic [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]     baseline;
  logic [NUM_BINS-1:0]  bin_vld;

  // Per-word working registers
  logic [MAG_W-1:0]     mag_sh;
  logic [MAG_W-1:0]     prev_sh;
  logic [ACC_W-1:0]     acc_sh;
  logic [ACC_W-1:0]     sum_sh;
  logic                 borrow;
  logic                 carry;
  logic [POS_W-1:0]     wr_addr;
  logic                 last_q;
  logic                 prev_vld;
  logic [CNT_W-1:0]     cnt;

  // Multiply and divide registers
  logic [HI_W-1:0]      d_reg;
  logic [HI_W-1:0]      hi;
  logic [ALPHA_W-1:0]   lo;
  logic [ACC_W:0]       v_reg;
  logic [ACC_W:0]       rem;
  logic [NOV_W-1:0]     dl;
  logic [NOV_W-1:0]     q;
  logic                 sat;

  // Handshake and control
  logic                 in_accept;
  logic                 pos_last;
  logic                 out_free;
  logic                 out_load;
  logic                 ram_re;
  logic                 ram_we;
  logic [MAG_W-1:0]     ram_rdata;

  // Serial slice and wide datapath terms
  logic                 m_bit, p_bit, a_bit, d_bit, s_bit;
  logic                 borrow_next, carry_next;
  logic [ACC_W-1:0]     sum_full;
  logic [HI_W-1:0]      hi_sum;
  logic [PROD_W-1:0]    mix;
  logic [ACC_W+1:0]     t_div;
  logic [ACC_W+1:0]     t_sub;
  logic                 t_ge;
  logic [NOV_W-1:0]     nov_final;

  assign in_accept = in_valid && !in_stall;
  assign pos_last  = (pos == POS_W'(NUM_BINS - 1));
  assign out_free  = !out_valid || !out_stall;

  // One bit of subtract and one bit of accumulate per cycle, LSB first
  assign m_bit       = mag_sh[0];
  assign p_bit       = prev_sh[0];
  assign a_bit       = acc_sh[0];
  assign d_bit       = m_bit ^ p_bit ^ borrow;
  assign borrow_next = (~m_bit & p_bit) | (~(m_bit ^ p_bit) & borrow);
  assign s_bit       = a_bit ^ d_bit ^ carry;
  assign carry_next  = (a_bit & d_bit) | (carry & (a_bit ^ d_bit));
  assign sum_full    = {s_bit, sum_sh[ACC_W-1:1]};

  // Shift-add step of alpha * (baseline - flux)
  assign hi_sum = hi + (lo[0] ? d_reg : '0);

  // flux * 2^16 + alpha * (baseline - flux) + half LSB
  assign mix = {2'b00, acc, {ALPHA_W{1'b0}}} + {hi, lo} + ROUND_HALF;

  // Restoring divide step
  assign t_div = {rem, dl[NOV_W-1]};
  assign t_sub = t_div - {1'b0, v_reg};
  assign t_ge  = (t_div >= {1'b0, v_reg});

  assign nov_final = (sat || (q > NOVELTY_MAX)) ? NOVELTY_MAX : q;

  // Previous-frame bin store
  sfn_ram #(
    .WIDTH (MAG_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (mag_sh),
    .re    (ram_re),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_word.kind == KIND_CLEAR) begin
            state_next = ST_IDLE;
          end else if (!enabled) begin
            state_next = pos_last ? ST_EMIT : ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ:  state_next = ST_ACCUM;
      ST_ACCUM: begin
        if (cnt == CNT_W'(ACC_STEPS - 1)) begin
          state_next = last_q ? ST_MPREP : ST_IDLE;
        end
      end
      ST_MPREP: state_next = ST_MULT;
      ST_MULT: begin
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          state_next = ST_MIX;
        end
      end
      ST_MIX:   state_next = ST_DINIT;
      ST_DINIT: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall = (state != ST_IDLE);
    ram_re   = (state == ST_IDLE) && in_valid && (in_word.kind == KIND_SAMPLE) && enabled;
    ram_we   = (state == ST_READ);
    out_load = (state == ST_EMIT) && out_free;
  end

  // Control state, frame state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      enabled        <= 1'b0;
      baseline_alpha <= ALPHA_RESET;
      pos            <= '0;
      acc            <= '0;
      baseline       <= ACC_W'(1);
      bin_vld        <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      // Take configuration writes
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ENABLED: enabled        <= cfg_data[0];
          REG_ALPHA:   baseline_alpha <= cfg_data[ALPHA_W-1:0];
        endcase
      end

      // Clear history or advance the bin position
      if (in_accept) begin
        if (in_word.kind == KIND_CLEAR) begin
          bin_vld  <= '0;
          acc      <= '0;
          baseline <= ACC_W'(1);
          pos      <= '0;
        end else begin
          pos <= pos_last ? '0 : pos + 1'b1;
          if (!enabled) begin
            acc <= '0;
          end
        end
      end

      // Mark the bin as written
      if (ram_we) begin
        bin_vld[wr_addr] <= 1'b1;
      end

      // Commit the rectified sum, saturated
      if ((state == ST_ACCUM) && (cnt == CNT_W'(ACC_STEPS - 1)) && !borrow_next) begin
        acc <= carry_next ? ACC_MAX : sum_full;
      end

      // Update the baseline
      if (state == ST_MIX) begin
        baseline <= mix[ALPHA_W +: ACC_W];
      end

      // Restart the accumulator after a result
      if (out_load) begin
        acc <= '0;
      end

      // Hold the result until it is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Serial datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          mag_sh   <= in_word.magnitude;
          wr_addr  <= pos;
          last_q   <= pos_last;
          prev_vld <= bin_vld[pos];
          q        <= '0;
          sat      <= 1'b0;
        end
      end
      ST_READ: begin
        prev_sh <= prev_vld ? ram_rdata : '0;
        acc_sh  <= acc;
        borrow  <= 1'b0;
        carry   <= 1'b0;
        cnt     <= '0;
      end
      ST_ACCUM: begin
        mag_sh  <= {1'b0, mag_sh[MAG_W-1:1]};
        prev_sh <= {1'b0, prev_sh[MAG_W-1:1]};
        acc_sh  <= {1'b0, acc_sh[ACC_W-1:1]};
        sum_sh  <= sum_full;
        borrow  <= borrow_next;
        carry   <= carry_next;
        cnt     <= cnt + 1'b1;
      end
      ST_MPREP: begin
        d_reg <= {2'b00, baseline} - {2'b00, acc};
        hi    <= '0;
        lo    <= baseline_alpha;
        cnt   <= '0;
      end
      ST_MULT: begin
        hi  <= {hi_sum[HI_W-1], hi_sum[HI_W-1:1]};
        lo  <= {hi_sum[0], lo[ALPHA_W-1:1]};
        cnt <= cnt + 1'b1;
      end
      ST_DINIT: begin
        v_reg <= {1'b0, baseline} + 1'b1;
        rem   <= (ACC_W+1)'(acc >> (NOV_W - FRAC_W));
        sat   <= ((ACC_W+1)'(acc >> (NOV_W - FRAC_W)) >= ({1'b0, baseline} + 1'b1));
        dl    <= {acc[NOV_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
        q     <= '0;
        cnt   <= '0;
      end
      ST_DIV: begin
        rem <= t_ge ? t_sub[ACC_W:0] : t_div[ACC_W:0];
        q   <= {q[NOV_W-2:0], t_ge};
        dl  <= {dl[NOV_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      ST_EMIT: begin
        if (out_load) begin
          out_word.novelty        <= nov_final;
          out_word.flux_sum       <= acc;
          out_word.baseline_level <= baseline;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/sfn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the previous-frame bin store.
module sfn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: tb/spectral_flux_novelty_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for spectral_flux_novelty_core: directed frames, then random frame
// streams under random input gaps and output stalls. Depends on sfn_pkg and the core's RTL.
module spectral_flux_novelty_core_tb;
  import sfn_pkg::*;

  localparam int SETTLE_CYCLES     = 80;
  localparam int WATCHDOG_LIMIT    = 4000;
  localparam int RANDOM_WORDS      = 850;
  localparam logic [MAG_W-1:0] MAG_FULL = '1;

  typedef enum int {
    PAT_RANDOM,
    PAT_QUIET,
    PAT_DRIFT,
    PAT_SILENT,
    PAT_FULL,
    PAT_ONSET
  } frame_pattern_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Expected behavior: own copy of history, baseline and registers
  logic [MAG_W-1:0]   prior_mag [NUM_BINS];
  logic [ACC_W-1:0]   flux_run;
  logic [ACC_W-1:0]   base_lvl;
  int unsigned        bin_idx;
  logic               en_reg;
  logic [ALPHA_W-1:0] alpha_reg;
  out_word_t          frames_due[$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;

  spectral_flux_novelty_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_flux_history();
    foreach (prior_mag[i]) prior_mag[i] = '0;
    flux_run = '0;
    base_lvl = ACC_W'(1);
    bin_idx  = 0;
  endfunction

  // Advance the expected state by one accepted word; queue the frame result on the last bin
  function automatic void predict_flux_word(in_word_t w);
    int unsigned      pos;
    bit               at_end;
    logic [63:0]      sum;
    logic [63:0]      mix;
    logic [63:0]      ratio;
    logic [ACC_W-1:0] flux;
    out_word_t        res;
    if (w.kind == KIND_CLEAR) begin
      clear_flux_history();
      return;
    end
    pos = bin_idx;
    at_end = (pos == NUM_BINS - 1);
    bin_idx = at_end ? 0 : pos + 1;
    if (!en_reg) begin
      flux_run = '0;
      if (at_end) begin
        res.novelty = '0;
        res.flux_sum = '0;
        res.baseline_level = base_lvl;
        frames_due.push_back(res);
      end
      return;
    end
    if (w.magnitude > prior_mag[pos]) begin
      sum = 64'(flux_run) + 64'(w.magnitude - prior_mag[pos]);
      flux_run = (sum > 64'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
    end
    prior_mag[pos] = w.magnitude;
    if (!at_end) return;
    // EMA baseline, rounded half up, then the normalized flux
    flux = flux_run;
    mix = 64'(alpha_reg) * 64'(base_lvl) + (64'd65536 - 64'(alpha_reg)) * 64'(flux)
          + 64'd32768;
    base_lvl = mix[16 +: ACC_W];
    ratio = (64'(flux) << FRAC_W) / (64'(base_lvl) + 64'd1);
    res.novelty = (ratio > 64'(NOVELTY_MAX)) ? NOVELTY_MAX : ratio[NOV_W-1:0];
    res.flux_sum = flux;
    res.baseline_level = base_lvl;
    frames_due.push_back(res);
    flux_run = '0;
  endfunction

  function automatic logic [MAG_W-1:0] pick_magnitude(frame_pattern_t pat);
    int nudged;
    case (pat)
      PAT_RANDOM: return MAG_W'($urandom);
      PAT_QUIET:  return MAG_W'($urandom_range(0, 4095));
      PAT_DRIFT: begin
        nudged = int'(prior_mag[bin_idx]) + int'($urandom_range(0, 1024)) - 512;
        if (nudged < 0) nudged = 0;
        if (nudged > int'(MAG_FULL)) nudged = int'(MAG_FULL);
        return MAG_W'(nudged);
      end
      PAT_SILENT: return '0;
      PAT_FULL:   return MAG_FULL;
      default: begin
        if ($urandom_range(0, 15) == 0) return MAG_FULL - MAG_W'($urandom_range(0, 255));
        return MAG_W'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // Predict on every accepted input word
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) predict_flux_word(in_word);
  end

  // Compare each accepted result word with the oldest expected frame
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d", $time,
                 out_word.novelty, out_word.flux_sum, out_word.baseline_level);
      end else begin
        want = frames_due.pop_front();
        if (out_word.novelty !== want.novelty) begin
          mismatch_count++;
          $display("%0t: novelty mismatch, expected %0d, actual %0d", $time,
                   want.novelty, out_word.novelty);
        end
        if (out_word.flux_sum !== want.flux_sum) begin
          mismatch_count++;
          $display("%0t: flux_sum mismatch, expected %0d, actual %0d", $time,
                   want.flux_sum, out_word.flux_sum);
        end
        if (out_word.baseline_level !== want.baseline_level) begin
          mismatch_count++;
          $display("%0t: baseline_level mismatch, expected %0d, actual %0d", $time,
                   want.baseline_level, out_word.baseline_level);
        end
      end
    end
  end

  // Drop the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stall the result channel in random bursts
  initial begin : drive_out_stall
    int unsigned hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && stalls_on && $urandom_range(0, 2) == 0) hold = pick_gap();
      out_stall <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  // Present one word, hold it until accepted
  task automatic send_word(input logic kind_bit, input logic [MAG_W-1:0] mag);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= {kind_bit, mag};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_bins(input frame_pattern_t pat, input int unsigned count);
    repeat (count) send_word(KIND_SAMPLE, pick_magnitude(pat));
  endtask

  // Idle the input, wait for every expected result, then let the core finish
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (frames_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain_and_settle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_ENABLED) en_reg = val[0];
    else alpha_reg = val[ALPHA_W-1:0];
  endtask

  // Reset state: disabled, so frames give zero novelty; clear works anyway
  task automatic test_disabled_after_reset();
    send_bins(PAT_FULL, NUM_BINS);
    send_bins(PAT_RANDOM, 10);
    send_word(KIND_CLEAR, MAG_FULL);
    send_bins(PAT_RANDOM, NUM_BINS);
  endtask

  // Full-scale and silent frames across alpha extremes; baseline reaching zero, saturation
  task automatic test_extreme_frames();
    write_reg(REG_ENABLED, 16'hFFFF);
    send_bins(PAT_FULL, NUM_BINS);
    send_bins(PAT_SILENT, NUM_BINS);
    send_bins(PAT_FULL, NUM_BINS);
    write_reg(REG_ALPHA, '0);
    send_bins(PAT_SILENT, NUM_BINS);
    send_bins(PAT_SILENT, NUM_BINS);
    write_reg(REG_ALPHA, '1);
    send_bins(PAT_FULL, NUM_BINS);
    send_bins(PAT_FULL, NUM_BINS);
  endtask

  // Clear in the middle of a frame restarts it with empty history
  task automatic test_clear_midframe();
    write_reg(REG_ALPHA, ALPHA_RESET);
    send_bins(PAT_RANDOM, 20);
    send_word(KIND_CLEAR, '0);
    send_bins(PAT_FULL, NUM_BINS);
  endtask

  // Enable and disable partway through a frame
  task automatic test_enable_midframe();
    write_reg(REG_ENABLED, 16'h0000);
    send_bins(PAT_SILENT, 30);
    write_reg(REG_ENABLED, 16'h0001);
    send_bins(PAT_RANDOM, NUM_BINS - 30);
    send_bins(PAT_ONSET, 25);
    write_reg(REG_ENABLED, 16'hFFFE);
    send_bins(PAT_RANDOM, NUM_BINS - 25);
    write_reg(REG_ENABLED, 16'h0001);
  endtask

  // Phases of random frames, with stray clear words, across register settings
  task automatic test_random_streams();
    int unsigned        phase;
    int unsigned        words_sent;
    logic [ALPHA_W-1:0] alpha_pick;
    logic [CFG_DATA_W-1:0] en_data;
    frame_pattern_t     pat;
    phase = 0;
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      case (phase % 5)
        0: alpha_pick = ALPHA_RESET;
        1: alpha_pick = '0;
        2: alpha_pick = '1;
        3: alpha_pick = 16'h8000;
        default: alpha_pick = ALPHA_W'($urandom);
      endcase
      write_reg(REG_ALPHA, alpha_pick);
      en_data = CFG_DATA_W'($urandom);
      en_data[0] = (phase % 7 != 3);
      write_reg(REG_ENABLED, en_data);
      gaps_on = (phase % 3 != 0);
      stalls_on = (phase % 4 != 1);
      repeat (2) begin
        pat = frame_pattern_t'($urandom_range(0, 5));
        repeat (NUM_BINS) begin
          if ($urandom_range(0, 149) == 0) begin
            send_word(KIND_CLEAR, MAG_W'($urandom));
            words_sent++;
          end
          send_word(KIND_SAMPLE, pick_magnitude(pat));
          words_sent++;
        end
      end
      phase++;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    clear_flux_history();
    en_reg = 1'b0;
    alpha_reg = ALPHA_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_disabled_after_reset();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_extreme_frames();
    test_clear_midframe();
    test_enable_midframe();
    test_random_streams();

    drain_and_settle();
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
